// ===== src/egg_pkg.sv =====
// shared types and constants of the elias gamma gap encoder
package egg_pkg;

  localparam int POS_W    = 32;  // width of the position field
  localparam int BYTE_W   = 8;
  localparam int PEND_W   = 7;   // leftover code bits, left aligned
  localparam int PCNT_W   = 3;
  localparam int STREAM_W = 72;  // pending bits plus the longest code word, byte padded
  localparam int LEN_W    = 7;
  localparam int SHIFT_W  = 5;
  localparam int STEP_W   = 3;

  localparam logic [STEP_W-1:0] LAST_STEP = 3'd4;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_NORM  = 5'b00010,
    ST_PLACE = 5'b00100,
    ST_EMIT  = 5'b01000,
    ST_ERR   = 5'b10000
  } state_t;

  typedef struct packed {
    logic load;
    logic norm;
    logic place;
    logic emit;
    logic err_out;
  } cmd_t;

  typedef struct packed {
    logic bad;
    logic norm_last;
    logic emit_final;
    logic out_free;
  } stat_t;

endpackage

// ===== src/egg_ctrl.sv =====
// controller state machine of the elias gamma gap encoder
module egg_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output egg_pkg::cmd_t cmd,
  input  egg_pkg::stat_t stat
);
  import egg_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = stat.bad ? ST_ERR : ST_NORM;
        end
      end
      ST_ERR: begin
        if (stat.out_free) begin
          cmd.err_out = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      ST_NORM: begin
        cmd.norm = 1'b1;
        if (stat.norm_last) begin
          state_next = ST_PLACE;
        end
      end
      ST_PLACE: begin
        cmd.place  = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.emit_final) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== src/egg_datapath.sv =====
// datapath: gap compute, leading-one normalizer, bit stream packer and output register
module egg_datapath #(
  parameter int VALUE_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  egg_pkg::cmd_t                 cmd,
  output egg_pkg::stat_t                stat,
  input  logic [egg_pkg::POS_W-1:0]     in_pos,
  input  logic                          in_end,
  output logic [egg_pkg::BYTE_W-1:0]    out_byte,
  output logic                          out_last,
  output logic                          out_bad,
  output logic                          out_valid,
  input  logic                          out_ready
);
  import egg_pkg::*;

  localparam int ALIGN = POS_W - VALUE_BITS;

  // list state
  logic [VALUE_BITS-1:0] prev_pos;
  logic                  at_start;
  logic [PEND_W-1:0]     pend_left;
  logic [PCNT_W-1:0]     pend_cnt;

  // per item work registers
  logic [VALUE_BITS-1:0] pos_r;
  logic                  last_r;
  logic [POS_W-1:0]      norm;
  logic [SHIFT_W-1:0]    lz;
  logic [STEP_W-1:0]     step;
  logic [STREAM_W-1:0]   stream;
  logic [LEN_W-1:0]      len;

  logic [VALUE_BITS-1:0] pos_in;
  logic [VALUE_BITS-1:0] value;
  logic                  bad;

  assign pos_in = in_pos[VALUE_BITS-1:0];

  // gap, or position+1 at the head of a list
  always_comb begin
    if (at_start) begin
      bad   = &pos_in;
      value = pos_in + VALUE_BITS'(1);
    end else begin
      bad   = (pos_in <= prev_pos);
      value = pos_in - prev_pos;
    end
  end

  // one step of the binary leading-zero search: 16, 8, 4, 2, 1
  logic [SHIFT_W-1:0] amt;
  logic               top_zero;
  always_comb begin
    case (step)
      3'd0:    amt = 5'd16;
      3'd1:    amt = 5'd8;
      3'd2:    amt = 5'd4;
      3'd3:    amt = 5'd2;
      default: amt = 5'd1;
    endcase
    top_zero = ~|(norm & ~({POS_W{1'b1}} >> amt));
  end

  // placement of the code word behind the pending bits
  logic [SHIFT_W-1:0]  n_top;
  logic [5:0]          place_amt;
  logic [STREAM_W-1:0] stream_place;
  logic [LEN_W-1:0]    len_place;
  always_comb begin
    n_top        = SHIFT_W'(POS_W - 1) - lz;
    place_amt    = 6'(pend_cnt) + 6'(n_top);
    stream_place = {pend_left, {(STREAM_W-PEND_W){1'b0}}}
                 | ({norm, {(STREAM_W-POS_W){1'b0}}} >> place_amt);
    len_place    = LEN_W'(pend_cnt) + LEN_W'({n_top, 1'b0}) + LEN_W'(1);
  end

  // byte emission
  logic                has_byte;
  logic [LEN_W-1:0]    rem_len;
  logic [STREAM_W-1:0] rem_stream;
  logic                emit_final;
  logic                emit_write;
  always_comb begin
    has_byte   = (len >= LEN_W'(BYTE_W));
    rem_len    = has_byte ? (len - LEN_W'(BYTE_W)) : len;
    rem_stream = has_byte ? (stream << BYTE_W) : stream;
    if (has_byte) begin
      emit_final = (rem_len < LEN_W'(BYTE_W)) && !(last_r && (rem_len != '0));
    end else begin
      emit_final = 1'b1;
    end
    // a short tail leaves only as the zero padded flush byte
    emit_write = has_byte || (last_r && (len != '0));
  end

  assign stat.bad        = bad;
  assign stat.norm_last  = (step == LAST_STEP);
  assign stat.emit_final = emit_final;
  assign stat.out_free   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pos_r  <= pos_in;
      last_r <= in_end;
      norm   <= POS_W'(value) << ALIGN;
      lz     <= '0;
      step   <= '0;
    end else if (cmd.norm) begin
      step <= step + STEP_W'(1);
      if (top_zero) begin
        norm <= norm << amt;
        lz   <= lz + amt;
      end
    end
    if (cmd.place) begin
      stream <= stream_place;
      len    <= len_place;
    end else if (cmd.emit) begin
      stream <= rem_stream;
      len    <= rem_len;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_pos  <= '0;
      at_start  <= 1'b1;
      pend_left <= '0;
      pend_cnt  <= '0;
    end else if (cmd.emit && emit_final) begin
      if (last_r) begin
        prev_pos  <= '0;
        at_start  <= 1'b1;
        pend_left <= '0;
        pend_cnt  <= '0;
      end else begin
        prev_pos  <= pos_r;
        at_start  <= 1'b0;
        pend_left <= rem_stream[STREAM_W-1 -: PEND_W];
        pend_cnt  <= rem_len[PCNT_W-1:0];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.err_out || (cmd.emit && emit_write)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.err_out) begin
      out_byte <= '0;
      out_last <= 1'b1;
      out_bad  <= 1'b1;
    end else if (cmd.emit && emit_write) begin
      out_byte <= stream[STREAM_W-1 -: BYTE_W];
      out_last <= emit_final;
      out_bad  <= 1'b0;
    end
  end

endmodule

// ===== src/elias_gamma_gap_encoder.sv =====
// elias gamma gap encoder top level: one item at a time, bytes leave through an output register
// an item holds the input through the accept, 5 normalizer steps, the placement and one code
// byte per cycle while the output is free (at least one); out-of-order items send an error beat
// the first byte of an item reaches the output register after the normalizer and placement
// rate is set by the five-step leading-zero normalizer and the single byte output port
// synchronous active-high reset clears the list state, the controller and the output valid
module elias_gamma_gap_encoder #(
  parameter int VALUE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] position
  input  logic        s_axis_tlast,   // list_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic        m_axis_tlast,   // run_last
  output logic        m_axis_tuser    // [0] bad_order
);
  import egg_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  egg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  egg_datapath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_pos    (s_axis_tdata),
    .in_end    (s_axis_tlast),
    .out_byte  (m_axis_tdata),
    .out_last  (m_axis_tlast),
    .out_bad   (m_axis_tuser),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready)
  );

endmodule

// ===== src/egg_checker.sv =====
// port-level assertions of the elias gamma gap encoder and their bind
module egg_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata,
  input logic        m_axis_tlast,
  input logic        m_axis_tuser
);

  // an error beat carries a zero byte and closes its item
  a_err_beat: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> (m_axis_tdata == 8'h00) && m_axis_tlast)
    else $error("error beat with data or without last");

  // one item at a time: no second beat right after an accepted one
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready right after an accepted beat");

  // nothing leaves in the cycle after reset
  a_reset_out: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast) && $stable(m_axis_tuser))
    else $error("stalled output beat changed");

endmodule

bind elias_gamma_gap_encoder egg_checker u_egg_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);
